// ===== rtl/core/pbcr_pkg.sv =====
// Package for the PT broadcast cache replacement block.
// Beat types, mode codes, field widths and parameter defaults; no dependencies.
`default_nettype none

package pbcr_pkg;

	localparam int MAX_SLOTS_DEF = 64;
	localparam int NUM_PAGES_DEF = 16;

	localparam int MODE_W = 2;
	localparam int SLOT_W_IN = 6;
	localparam int PAGE_W = 4;
	localparam int PROB_W = 16;
	localparam int PT_W = 22;
	localparam int CFG_W = 7;

	localparam logic [PT_W-1:0] PT_MAX = {PT_W{1'b1}};

	typedef enum logic [MODE_W-1:0] {
		MODE_SLOT = 2'd0,
		MODE_PROB = 2'd1,
		MODE_STEP = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                 mode;
		logic [SLOT_W_IN-1:0]  slot;
		logic [PAGE_W-1:0]     page;
		logic [PROB_W-1:0]     probability;
	} in_beat_t;

	typedef struct packed {
		logic [PAGE_W-1:0] cached_page;
		logic              cached_valid;
		logic              replaced;
		logic [PT_W-1:0]   item_pt;
		logic [PT_W-1:0]   held_pt;
		logic              bad_slot;
	} out_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pbcr_sched_mem.sv =====
// Broadcast schedule store: one page number per slot, one write and one read port.
// Read data is registered. Uses pbcr_pkg for the page width.
`default_nettype none

module pbcr_sched_mem
	import pbcr_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int SLOT_W    = $clog2(MAX_SLOTS)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire logic [PAGE_W-1:0] wr_page,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output logic      [PAGE_W-1:0] rd_page
);

	logic [PAGE_W-1:0] mem_q [MAX_SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_page;
		end
		rd_page <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/pbcr_prob_mem.sv =====
// Per-page probability store, Q0.16, with a valid bit per entry so that it reads zero
// after reset. Registered read. Uses pbcr_pkg for the probability width.
`default_nettype none

module pbcr_prob_mem
	import pbcr_pkg::*;
#(
	parameter int NUM_PAGES = NUM_PAGES_DEF,
	parameter int PG_W      = $clog2(NUM_PAGES)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [PG_W-1:0]   wr_idx,
	input  wire logic [PROB_W-1:0] wr_prob,
	input  wire logic              rd_ok,
	input  wire logic [PG_W-1:0]   rd_idx,
	output logic      [PROB_W-1:0] rd_prob
);

	logic [PROB_W-1:0] mem_q [NUM_PAGES];
	logic [NUM_PAGES-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// an entry never written reads as zero probability
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_prob;
		end
		rd_prob <= (rd_ok && vld_q[rd_idx]) ? mem_q[rd_idx] : '0;
	end

endmodule

`default_nettype wire

// ===== rtl/core/pbcr_pt_unit.sv =====
// Shared PT multiplier: probability times distance, saturated to the PT width.
// Uses pbcr_pkg for the probability and PT widths.
`default_nettype none

module pbcr_pt_unit
	import pbcr_pkg::*;
#(
	parameter int LEN_W = 7
) (
	input  wire logic [PROB_W-1:0] prob,
	input  wire logic [LEN_W-1:0]  span,
	output logic      [PT_W-1:0]   pt
);

	localparam int PROD_W = (PROB_W + LEN_W > PT_W) ? PROB_W + LEN_W : PT_W;

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(prob) * PROD_W'(span);
	assign pt   = (prod > PROD_W'(PT_MAX)) ? PT_MAX : prod[PT_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/pt_broadcast_cache_replacement.sv =====
// PT replacement for a one-entry cache fed by a cyclic broadcast schedule. Mode 0 beats
// write a schedule slot, mode 1 beats write a page probability (Q0.16), mode 2 beats are
// broadcast steps; every input beat yields exactly one output beat. Load, unused-mode and
// bad-slot beats go from acceptance straight to the done state. A step on a full cache
// passes the item, scan, probability, multiply and compare states: the sequencer walks the
// schedule memory through its single read port, one slot a cycle, finding the next
// broadcast of both pages in one pass, then reads both probabilities and runs them through
// one shared multiplier. A step that fills an empty cache goes from the item state to the
// done state. The input is not ready while a step is being worked; the output register lets
// a new beat be taken while the previous result still waits downstream. schedule_length is
// written through cfg_wr_en / cfg_wr_data and should only change while the block is idle.
// Depends on pbcr_pkg, pbcr_sched_mem, pbcr_prob_mem and pbcr_pt_unit.
`default_nettype none

module pt_broadcast_cache_replacement
	import pbcr_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int NUM_PAGES = NUM_PAGES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_beat_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_beat_t             out_data,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data
);

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int LEN_W  = $clog2(MAX_SLOTS + 1);
	localparam int PG_W   = $clog2(NUM_PAGES);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_ITEM   = 8'b0000_0010,
		ST_SCAN   = 8'b0000_0100,
		ST_PROB_I = 8'b0000_1000,
		ST_PROB_H = 8'b0001_0000,
		ST_MUL_H  = 8'b0010_0000,
		ST_CMP    = 8'b0100_0000,
		ST_DONE   = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    len_cfg_q;
	logic [LEN_W-1:0]    len_eff;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    slot_q;
	logic [LEN_W-1:0]    idx_q;
	logic [LEN_W-1:0]    idx_inc;
	logic [LEN_W-1:0]    slot_inc;
	logic [LEN_W-1:0]    k_q;
	logic                issue_q;
	logic                chk_vld_s1;
	logic [LEN_W-1:0]    chk_k_s1;
	logic                item_fnd_q;
	logic                held_fnd_q;
	logic [LEN_W-1:0]    item_dist_q;
	logic [LEN_W-1:0]    held_dist_q;
	logic                held_vld_q;
	logic [PAGE_W-1:0]   held_pg_q;
	logic [PAGE_W-1:0]   item_pg_q;
	logic                res_rep_q;
	logic                res_bad_q;
	logic [PT_W-1:0]     item_pt_q;
	logic [PT_W-1:0]     held_pt_q;
	logic                out_valid_q;
	out_beat_t           out_data_q;

	logic                accept;
	logic                step_bad;
	logic                sched_we;
	logic [SLOT_W-1:0]   sched_rd_addr;
	logic [PAGE_W-1:0]   sched_rd;
	logic                prob_we;
	logic [PAGE_W-1:0]   prob_rd_pg;
	logic                prob_rd_ok;
	logic [PROB_W-1:0]   prob_rd;
	logic [LEN_W-1:0]    mul_dist;
	logic [PT_W-1:0]     mul_pt;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// saturate the length to the store depth
	assign len_eff  = (32'(len_cfg_q) > MAX_SLOTS) ? LEN_W'(MAX_SLOTS) : LEN_W'(len_cfg_q);
	assign step_bad = 32'(in_data.slot) >= 32'(len_eff);

	assign idx_inc  = idx_q + LEN_W'(1);
	assign slot_inc = slot_q + LEN_W'(1);

	assign sched_we = accept && (in_data.mode == MODE_SLOT) && (32'(in_data.slot) < MAX_SLOTS);
	assign sched_rd_addr = (state_q == ST_IDLE) ? SLOT_W'(in_data.slot) : idx_q[SLOT_W-1:0];

	assign prob_we    = accept && (in_data.mode == MODE_PROB) && (32'(in_data.page) < NUM_PAGES);
	assign prob_rd_pg = (state_q == ST_PROB_I) ? item_pg_q : held_pg_q;
	assign prob_rd_ok = 32'(prob_rd_pg) < NUM_PAGES;

	assign mul_dist = (state_q == ST_PROB_H) ? item_dist_q : held_dist_q;

	pbcr_sched_mem #(
		.MAX_SLOTS (MAX_SLOTS),
		.SLOT_W    (SLOT_W)
	) u_sched (
		.clk     (clk),
		.wr_en   (sched_we),
		.wr_addr (SLOT_W'(in_data.slot)),
		.wr_page (in_data.page),
		.rd_addr (sched_rd_addr),
		.rd_page (sched_rd)
	);

	pbcr_prob_mem #(
		.NUM_PAGES (NUM_PAGES),
		.PG_W      (PG_W)
	) u_prob (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (prob_we),
		.wr_idx  (PG_W'(in_data.page)),
		.wr_prob (in_data.probability),
		.rd_ok   (prob_rd_ok),
		.rd_idx  (PG_W'(prob_rd_pg)),
		.rd_prob (prob_rd)
	);

	pbcr_pt_unit #(
		.LEN_W (LEN_W)
	) u_pt (
		.prob (prob_rd),
		.span (mul_dist),
		.pt   (mul_pt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_cfg_q   <= CFG_W'(1);
			len_q       <= '0;
			slot_q      <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			issue_q     <= 1'b0;
			chk_vld_s1  <= 1'b0;
			chk_k_s1    <= '0;
			item_fnd_q  <= 1'b0;
			held_fnd_q  <= 1'b0;
			item_dist_q <= '0;
			held_dist_q <= '0;
			held_vld_q  <= 1'b0;
			held_pg_q   <= '0;
			item_pg_q   <= '0;
			res_rep_q   <= 1'b0;
			res_bad_q   <= 1'b0;
			item_pt_q   <= '0;
			held_pt_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				len_cfg_q <= cfg_wr_data;
			end
			// drop the sent beat unless a new one is loaded in its place
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						res_rep_q <= 1'b0;
						item_pt_q <= '0;
						held_pt_q <= '0;
						len_q     <= len_eff;
						slot_q    <= LEN_W'(in_data.slot);
						if (in_data.mode == MODE_STEP && !step_bad) begin
							res_bad_q <= 1'b0;
							state_q   <= ST_ITEM;
						end else begin
							res_bad_q <= (in_data.mode == MODE_STEP);
							state_q   <= ST_DONE;
						end
					end
				end
				ST_ITEM: begin
					if (!held_vld_q) begin
						held_pg_q  <= sched_rd;
						held_vld_q <= 1'b1;
						res_rep_q  <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						item_pg_q   <= sched_rd;
						idx_q       <= (slot_inc == len_q) ? '0 : slot_inc;
						k_q         <= LEN_W'(1);
						issue_q     <= 1'b1;
						item_fnd_q  <= 1'b0;
						held_fnd_q  <= 1'b0;
						item_dist_q <= len_q;
						held_dist_q <= len_q;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// issue one slot a cycle; its page comes back in the next cycle
					chk_vld_s1 <= issue_q;
					chk_k_s1   <= k_q;
					if (issue_q) begin
						idx_q <= (idx_inc == len_q) ? '0 : idx_inc;
						if (k_q == len_q) begin
							issue_q <= 1'b0;
						end else begin
							k_q <= k_q + LEN_W'(1);
						end
					end
					if (chk_vld_s1) begin
						if (!item_fnd_q && sched_rd == item_pg_q) begin
							item_fnd_q  <= 1'b1;
							item_dist_q <= chk_k_s1;
						end
						if (!held_fnd_q && sched_rd == held_pg_q) begin
							held_fnd_q  <= 1'b1;
							held_dist_q <= chk_k_s1;
						end
						if (chk_k_s1 == len_q) begin
							state_q <= ST_PROB_I;
						end
					end
				end
				ST_PROB_I: begin
					state_q <= ST_PROB_H;
				end
				ST_PROB_H: begin
					item_pt_q <= mul_pt;
					state_q   <= ST_MUL_H;
				end
				ST_MUL_H: begin
					held_pt_q <= mul_pt;
					state_q   <= ST_CMP;
				end
				ST_CMP: begin
					// replace only on strictly greater PT
					if (item_pt_q > held_pt_q) begin
						held_pg_q <= item_pg_q;
						res_rep_q <= 1'b1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q             <= 1'b1;
						out_data_q.cached_page  <= held_pg_q;
						out_data_q.cached_valid <= held_vld_q;
						out_data_q.replaced     <= res_rep_q;
						out_data_q.item_pt      <= item_pt_q;
						out_data_q.held_pt      <= held_pt_q;
						out_data_q.bad_slot     <= res_bad_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_held_never_lost: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(held_vld_q))
		else $error("cache valid dropped");

	a_replace_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.replaced |-> out_data_q.cached_valid && !out_data_q.bad_slot)
		else $error("replacement reported without a cached page");

	a_bad_is_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.bad_slot |->
			!out_data_q.replaced && out_data_q.item_pt == '0 && out_data_q.held_pt == '0)
		else $error("bad slot beat carries a result");

	a_scan_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> held_vld_q)
		else $error("scan started on an empty cache");

	a_dist_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PROB_I |-> item_dist_q <= len_q && held_dist_q <= len_q
			&& item_dist_q != '0 && held_dist_q != '0)
		else $error("distance outside one schedule cycle");
`endif

endmodule

`default_nettype wire
